### hdl/lmbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmbs_pkg: shared types and codes for the LED matrix BCM scanner
// Command codes, decoded operations, queue item layout, scan phases and the
// precomputed timing limits passed from the top level to the scan engine.
// ----------------------------------------------------------------------------
package lmbs_pkg;

    localparam int STORE_ADDR_W = 11;
    localparam int PIXEL_W      = 24;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_INDEX_W  = 3;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_TICKS_PER_US = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_ON_US   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_QUIET_US     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_GAP_US = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_REFRESH_HOLD = 3'd4;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_WRITE,
        OP_TOUCH,
        OP_CLEAR,
        OP_NONE
    } op_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SHIFT_LOW,
        PH_SHIFT_HIGH,
        PH_LATCH,
        PH_ON,
        PH_GAP
    } scan_phase_t;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_RUN,
        B_LOAD
    } back_state_t;

    typedef struct packed {
        op_t                     op;
        logic [STORE_ADDR_W-1:0] addr;
        logic [PIXEL_W-1:0]      pixel;
    } item_t;

    typedef struct packed {
        logic [23:0] quiet_limit;
        logic [23:0] gap_limit;
        logic [15:0] on_base;
        logic        hold;
    } limits_t;

endpackage

### hdl/lmbs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmbs_front: command decode and two-entry beat queue
// Classifies each input beat, checks pixel coordinates, forms the store
// address and packed pixel, and queues the result for the scan engine.
// ----------------------------------------------------------------------------
module lmbs_front #(
    parameter int PANEL_WIDTH  = 64,
    parameter int PANEL_HEIGHT = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [1:0]      command,
    input  logic [7:0]      column,
    input  logic [7:0]      line,
    input  logic [7:0]      red,
    input  logic [7:0]      green,
    input  logic [7:0]      blue,
    output logic            q_valid,
    output lmbs_pkg::item_t q_item,
    input  logic            q_pop
);
    import lmbs_pkg::*;

    item_t      dec_item;
    logic       in_range;
    logic       push;
    item_t      fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb
    begin
        in_range       = (column < 8'(PANEL_WIDTH)) && (line < 8'(PANEL_HEIGHT));
        dec_item.pixel = {blue, green, red};
        dec_item.addr  = STORE_ADDR_W'(line) * STORE_ADDR_W'(PANEL_WIDTH)
                       + STORE_ADDR_W'(column);
        case (command)
            CMD_TICK:  dec_item.op = OP_TICK;
            CMD_WRITE: dec_item.op = in_range ? OP_WRITE : OP_TOUCH;
            CMD_CLEAR: dec_item.op = OP_CLEAR;
            default:   dec_item.op = OP_NONE;
        endcase
    end

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= dec_item;
        end
    end

endmodule

### hdl/lmbs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmbs_back: scan engine, framebuffer and output register
// Runs the BCM scan sequence on tick beats, applies pixel writes and clears,
// sweeps the framebuffer after reset and on clear, and holds the result beat.
// ----------------------------------------------------------------------------
module lmbs_back #(
    parameter int PANEL_WIDTH  = 64,
    parameter int PANEL_HEIGHT = 32,
    parameter int COLOR_DEPTH  = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  lmbs_pkg::item_t     q_item,
    output logic                q_pop,
    input  lmbs_pkg::limits_t   limits,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [5:0]          color_bits,
    output logic                shift_clock,
    output logic [3:0]          row_address,
    output logic                latch,
    output logic                blank,
    output logic                frame_active,
    output logic                write_refused
);
    import lmbs_pkg::*;

    localparam int DEPTH = PANEL_WIDTH * PANEL_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int PAIRS = PANEL_HEIGHT / 2;
    localparam logic [2:0] PLANE_OFS = 3'(8 - COLOR_DEPTH);

    back_state_t  bstate_reg, bstate_next;
    scan_phase_t  phase_reg, phase_next;
    logic [2:0]   plane_reg, plane_next;
    logic [3:0]   pair_reg, pair_next;
    logic [5:0]   col_reg, col_next;
    logic [23:0]  timer_reg, timer_next;
    logic [23:0]  quiet_reg, quiet_next;
    logic [3:0]   held_reg, held_next;
    logic [5:0]   shift_reg, shift_next;
    logic [AW-1:0] sweep_reg, sweep_next;
    logic         out_valid_reg, out_valid_next;
    logic [5:0]   color_bits_reg;
    logic         shift_clock_reg, latch_reg, blank_reg, frame_active_reg, refused_reg;
    logic [3:0]   row_address_reg;

    scan_phase_t  t_phase;
    logic [2:0]   t_plane;
    logic [3:0]   t_pair;
    logic [5:0]   t_col;
    logic [23:0]  t_timer, t_quiet;
    logic [3:0]   t_held;
    logic         t_load;
    logic [23:0]  timer_inc, on_limit;
    logic [6:0]   col_inc;
    logic [4:0]   pair_inc;
    logic [3:0]   plane_inc;

    logic [PIXEL_W-1:0] mem [DEPTH];
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [PIXEL_W-1:0] mem_wdata;
    logic               rd_en;
    logic [AW-1:0]      rd_top_addr, rd_bot_addr;
    logic [PIXEL_W-1:0] rd_top_reg, rd_bot_reg;
    logic [2:0]         bit_sel;

    logic active, can_emit, emit, refused;

    assign active   = (phase_reg == PH_SHIFT_LOW) || (phase_reg == PH_SHIFT_HIGH)
                   || (phase_reg == PH_LATCH) || (phase_reg == PH_ON);
    assign can_emit = !out_valid_reg || !out_stall;

    // one tick of the scan sequence
    always_comb
    begin
        t_quiet   = (quiet_reg == 24'hFFFFFF) ? quiet_reg : quiet_reg + 24'd1;
        timer_inc = timer_reg + 24'd1;
        on_limit  = 24'(limits.on_base) << plane_reg;
        col_inc   = {1'b0, col_reg} + 7'd1;
        pair_inc  = {1'b0, pair_reg} + 5'd1;
        plane_inc = {1'b0, plane_reg} + 4'd1;
        t_phase   = phase_reg;
        t_plane   = plane_reg;
        t_pair    = pair_reg;
        t_col     = col_reg;
        t_timer   = timer_reg;
        t_held    = held_reg;
        t_load    = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (!limits.hold && (t_quiet >= limits.quiet_limit))
                begin
                    t_plane = 3'd0;
                    t_pair  = 4'd0;
                    t_col   = 6'd0;
                    t_load  = 1'b1;
                    t_phase = PH_SHIFT_LOW;
                end
            end
            PH_SHIFT_LOW:
            begin
                t_phase = PH_SHIFT_HIGH;
            end
            PH_SHIFT_HIGH:
            begin
                if (col_inc < 7'(PANEL_WIDTH))
                begin
                    t_col   = col_inc[5:0];
                    t_load  = 1'b1;
                    t_phase = PH_SHIFT_LOW;
                end
                else
                begin
                    t_held  = pair_reg;
                    t_phase = PH_LATCH;
                end
            end
            PH_LATCH:
            begin
                t_timer = 24'd0;
                t_phase = PH_ON;
            end
            PH_ON:
            begin
                t_timer = timer_inc;
                if (timer_inc >= on_limit)
                begin
                    t_col   = 6'd0;
                    t_load  = 1'b1;
                    t_phase = PH_SHIFT_LOW;
                    t_pair  = pair_inc[3:0];
                    if (pair_inc >= 5'(PAIRS))
                    begin
                        t_pair  = 4'd0;
                        t_plane = plane_inc[2:0];
                        if (plane_inc >= 4'(COLOR_DEPTH))
                        begin
                            t_plane = 3'd0;
                            t_timer = 24'd0;
                            t_load  = 1'b0;
                            t_phase = PH_GAP;
                        end
                    end
                end
            end
            PH_GAP:
            begin
                t_timer = timer_inc;
                if (timer_inc >= limits.gap_limit)
                begin
                    t_timer = 24'd0;
                    t_phase = PH_IDLE;
                end
            end
            default:
            begin
                t_phase = PH_IDLE;
            end
        endcase
        rd_top_addr = AW'(t_pair) * AW'(PANEL_WIDTH) + AW'(t_col);
        rd_bot_addr = (AW'(t_pair) + AW'(PAIRS)) * AW'(PANEL_WIDTH) + AW'(t_col);
    end

    always_comb
    begin
        bstate_next = bstate_reg;
        phase_next  = phase_reg;
        plane_next  = plane_reg;
        pair_next   = pair_reg;
        col_next    = col_reg;
        timer_next  = timer_reg;
        quiet_next  = quiet_reg;
        held_next   = held_reg;
        shift_next  = shift_reg;
        sweep_next  = sweep_reg;
        q_pop       = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = sweep_reg;
        mem_wdata   = '0;
        rd_en       = 1'b0;
        emit        = 1'b0;
        refused     = 1'b0;
        bit_sel     = PLANE_OFS + plane_reg;
        case (bstate_reg)
            B_CLEAR:
            begin
                mem_we     = 1'b1;
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == AW'(DEPTH - 1))
                begin
                    sweep_next  = '0;
                    bstate_next = B_RUN;
                end
            end
            B_RUN:
            begin
                if (q_valid && can_emit)
                begin
                    q_pop = 1'b1;
                    case (q_item.op)
                        OP_TICK:
                        begin
                            phase_next = t_phase;
                            plane_next = t_plane;
                            pair_next  = t_pair;
                            col_next   = t_col;
                            timer_next = t_timer;
                            quiet_next = t_quiet;
                            held_next  = t_held;
                            if (t_load)
                            begin
                                rd_en       = 1'b1;
                                bstate_next = B_LOAD;
                            end
                            else
                            begin
                                emit = 1'b1;
                            end
                        end
                        OP_WRITE, OP_TOUCH, OP_CLEAR:
                        begin
                            emit = 1'b1;
                            if (active)
                            begin
                                refused = 1'b1;
                            end
                            else
                            begin
                                quiet_next = 24'd0;
                                if (q_item.op == OP_WRITE)
                                begin
                                    mem_we    = 1'b1;
                                    mem_waddr = q_item.addr[AW-1:0];
                                    mem_wdata = q_item.pixel;
                                end
                                if (q_item.op == OP_CLEAR)
                                begin
                                    bstate_next = B_CLEAR;
                                end
                            end
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            B_LOAD:
            begin
                if (can_emit)
                begin
                    shift_next  = {rd_bot_reg[{2'b10, bit_sel}], rd_bot_reg[{2'b01, bit_sel}],
                                   rd_bot_reg[{2'b00, bit_sel}], rd_top_reg[{2'b10, bit_sel}],
                                   rd_top_reg[{2'b01, bit_sel}], rd_top_reg[{2'b00, bit_sel}]};
                    emit        = 1'b1;
                    bstate_next = B_RUN;
                end
            end
            default:
            begin
                bstate_next = B_CLEAR;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bstate_reg    <= B_CLEAR;
            phase_reg     <= PH_IDLE;
            plane_reg     <= 3'd0;
            pair_reg      <= 4'd0;
            col_reg       <= 6'd0;
            timer_reg     <= 24'd0;
            quiet_reg     <= 24'd0;
            held_reg      <= 4'd0;
            shift_reg     <= 6'd0;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bstate_reg    <= bstate_next;
            phase_reg     <= phase_next;
            plane_reg     <= plane_next;
            pair_reg      <= pair_next;
            col_reg       <= col_next;
            timer_reg     <= timer_next;
            quiet_reg     <= quiet_next;
            held_reg      <= held_next;
            shift_reg     <= shift_next;
            sweep_reg     <= sweep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            color_bits_reg   <= shift_next;
            shift_clock_reg  <= (phase_next == PH_SHIFT_HIGH);
            row_address_reg  <= held_next;
            latch_reg        <= (phase_next == PH_LATCH);
            blank_reg        <= (phase_next != PH_ON);
            frame_active_reg <= (phase_next == PH_SHIFT_LOW) || (phase_next == PH_SHIFT_HIGH)
                             || (phase_next == PH_LATCH) || (phase_next == PH_ON);
            refused_reg      <= refused;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_top_reg <= mem[rd_top_addr];
            rd_bot_reg <= mem[rd_bot_addr];
        end
    end

    assign out_valid     = out_valid_reg;
    assign color_bits    = color_bits_reg;
    assign shift_clock   = shift_clock_reg;
    assign row_address   = row_address_reg;
    assign latch         = latch_reg;
    assign blank         = blank_reg;
    assign frame_active  = frame_active_reg;
    assign write_refused = refused_reg;

    a_clear_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (bstate_reg == B_CLEAR) |-> !q_pop)
        else $error("queue popped during store sweep");

    a_load_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (bstate_reg == B_LOAD) |-> (phase_reg == PH_SHIFT_LOW))
        else $error("column load outside shift phase");

    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && (bstate_reg == B_RUN)) |-> !active)
        else $error("pixel write during frame");

    a_pair_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, pair_reg} < 5'(PAIRS)))
        else $error("row pair out of range");

    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> !(out_valid_reg && out_stall))
        else $error("result overwrote a stalled beat");

endmodule

### hdl/led_matrix_bcm_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_bcm_scanner: HUB75 panel driver with BCM refresh
// Holds the configuration registers and timing limits, and joins the
// command front end to the scan engine and framebuffer.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_stall    command column line red green blue
//   out      source     out_valid/out_stall  color_bits shift_clock row_address
//                                            latch blank frame_active
//                                            write_refused
//   cfg      sink       cfg_we               cfg_index cfg_data
//
// One result beat per input beat. A tick that loads a new column first reads
// the store (B_LOAD state) and then gives its result. A clear taken outside a
// frame sweeps all PANEL_WIDTH*PANEL_HEIGHT store entries (2048 by default)
// and takes no new beat until it ends; the same sweep runs after reset.
// Input stalls while the two-entry queue is full; the output register holds
// a stalled beat while the engine waits.
// ----------------------------------------------------------------------------
module led_matrix_bcm_scanner #(
    parameter int PANEL_WIDTH  = 64,
    parameter int PANEL_HEIGHT = 32,
    parameter int COLOR_DEPTH  = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          command,
    input  logic [7:0]                          column,
    input  logic [7:0]                          line,
    input  logic [7:0]                          red,
    input  logic [7:0]                          green,
    input  logic [7:0]                          blue,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [5:0]                          color_bits,
    output logic                                shift_clock,
    output logic [3:0]                          row_address,
    output logic                                latch,
    output logic                                blank,
    output logic                                frame_active,
    output logic                                write_refused,
    input  logic                                cfg_we,
    input  logic [lmbs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lmbs_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import lmbs_pkg::*;

    logic [7:0]  tpu_reg;
    logic [7:0]  base_on_reg;
    logic [15:0] quiet_us_reg;
    logic [15:0] gap_us_reg;
    logic        hold_reg;
    logic [23:0] quiet_limit_reg;
    logic [23:0] gap_limit_reg;
    logic [15:0] on_base_reg;
    limits_t     limits;
    logic        q_valid;
    item_t       q_item;
    logic        q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpu_reg      <= 8'd25;
            base_on_reg  <= 8'd4;
            quiet_us_reg <= 16'd1000;
            gap_us_reg   <= 16'd1000;
            hold_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TICKS_PER_US: tpu_reg      <= cfg_data[7:0];
                REG_BASE_ON_US:   base_on_reg  <= cfg_data[7:0];
                REG_QUIET_US:     quiet_us_reg <= cfg_data;
                REG_FRAME_GAP_US: gap_us_reg   <= cfg_data;
                REG_REFRESH_HOLD: hold_reg     <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // microsecond counts scaled to ticks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_limit_reg <= 24'd25000;
            gap_limit_reg   <= 24'd25000;
            on_base_reg     <= 16'd100;
        end
        else
        begin
            quiet_limit_reg <= 24'(quiet_us_reg) * 24'(tpu_reg);
            gap_limit_reg   <= 24'(gap_us_reg) * 24'(tpu_reg);
            on_base_reg     <= 16'(base_on_reg) * 16'(tpu_reg);
        end
    end

    always_comb
    begin
        limits.quiet_limit = quiet_limit_reg;
        limits.gap_limit   = gap_limit_reg;
        limits.on_base     = on_base_reg;
        limits.hold        = hold_reg;
    end

    lmbs_front #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .command  (command),
        .column   (column),
        .line     (line),
        .red      (red),
        .green    (green),
        .blue     (blue),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    lmbs_back #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT),
        .COLOR_DEPTH  (COLOR_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .limits        (limits),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .color_bits    (color_bits),
        .shift_clock   (shift_clock),
        .row_address   (row_address),
        .latch         (latch),
        .blank         (blank),
        .frame_active  (frame_active),
        .write_refused (write_refused)
    );

endmodule

### tb/led_matrix_bcm_scanner_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_bcm_scanner_tb: self-checking bench for the LED matrix BCM scanner
// Starts with a short directed list of beats and register writes. Then come
// randomized phases, each under its own timing setup: a framebuffer fill with
// refresh held, a stretch of scanning at the fastest weighted timing, zero and
// maximum timings, refresh hold during a frame, and moderate and random
// setups. A beat-level model of the scan engine predicts every output beat,
// and each beat is compared field by field. Both sides idle at random, and
// the receiver once holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module led_matrix_bcm_scanner_tb;
    import lmbs_pkg::*;

    localparam int PANEL_WIDTH  = 64;
    localparam int PANEL_HEIGHT = 32;
    localparam int COLOR_DEPTH  = 8;
    localparam int STORE_DEPTH  = 2048;
    localparam int SWEEP_GUARD  = 2300;
    localparam int HOLDOFF_LEN  = 500;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [5:0] color;
        logic       sclk;
        logic [3:0] row_addr;
        logic       lat;
        logic       blanked;
        logic       active;
        logic       refused;
    } panel_beat_t;

    typedef enum logic {
        ROW_BEAT,
        ROW_REG
    } row_kind_t;

    typedef struct {
        row_kind_t               kind;
        logic [1:0]              cmd;
        logic [7:0]              x;
        logic [7:0]              y;
        logic [7:0]              r;
        logic [7:0]              g;
        logic [7:0]              b;
        logic [CFG_INDEX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0]   reg_val;
        bit                      typed;
        panel_beat_t             want;
    } plan_row_t;

    localparam panel_beat_t IDLE_LEVELS = '{color: 6'd0, sclk: 1'b0, row_addr: 4'd0,
        lat: 1'b0, blanked: 1'b1, active: 1'b0, refused: 1'b0};
    // first column of plane 0 shifting; bottom pixel (0,16) holds red and blue bit 0
    localparam panel_beat_t REFUSED_LEVELS = '{color: 6'h28, sclk: 1'b0, row_addr: 4'd0,
        lat: 1'b0, blanked: 1'b1, active: 1'b1, refused: 1'b1};

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [1:0]              command;
    logic [7:0]              column;
    logic [7:0]              line;
    logic [7:0]              red;
    logic [7:0]              green;
    logic [7:0]              blue;
    logic                    out_valid;
    logic                    out_stall;
    logic [5:0]              color_bits;
    logic                    shift_clock;
    logic [3:0]              row_address;
    logic                    latch;
    logic                    blank;
    logic                    frame_active;
    logic                    write_refused;
    logic                    cfg_we;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    led_matrix_bcm_scanner dut (.*);

    always #4 clk = ~clk;

    // scan model state
    logic [23:0]  pixel_mirror [0:STORE_DEPTH-1];
    scan_phase_t  phase_now;
    logic [2:0]   plane;
    logic [3:0]   pair;
    logic [5:0]   col;
    logic [23:0]  phase_ticks;
    logic [23:0]  quiet_ticks;
    logic [3:0]   row_hold;
    logic [5:0]   shift_hold;
    logic [7:0]   tpu_r;
    logic [7:0]   base_r;
    logic [15:0]  quiet_r;
    logic [15:0]  gap_r;
    logic         hold_r;

    panel_beat_t  panel_levels_q [$];
    plan_row_t    plan [$];
    int           mismatches = 0;
    bit           tx_idle_on = 1'b1;
    bit           rx_idle_on = 1'b1;
    bit           rx_holdoff = 1'b0;

    function automatic logic [23:0] pixel_at(input int unsigned y, input int unsigned x);
        int unsigned idx;
        idx = y * PANEL_WIDTH + x;
        return (idx < STORE_DEPTH) ? pixel_mirror[idx] : 24'd0;
    endfunction

    function void fetch_column();
        logic [23:0] top_px;
        logic [23:0] bot_px;
        int unsigned sh;
        sh = (8 - COLOR_DEPTH + 32'(plane)) % 8;
        top_px = pixel_at(32'(pair), 32'(col));
        bot_px = pixel_at(32'(pair) + PANEL_HEIGHT / 2, 32'(col));
        for (int c = 0; c < 3; c++)
        begin
            shift_hold[c]     = top_px[sh + 8 * c];
            shift_hold[c + 3] = bot_px[sh + 8 * c];
        end
    endfunction

    function void start_row();
        col = '0;
        fetch_column();
        phase_now = PH_SHIFT_LOW;
    endfunction

    function void advance_scan();
        int unsigned quiet_lim;
        int unsigned on_lim;
        int unsigned gap_lim;
        quiet_lim = 32'(quiet_r) * 32'(tpu_r);
        on_lim    = (32'(base_r) << plane) * 32'(tpu_r);
        gap_lim   = 32'(gap_r) * 32'(tpu_r);
        if (quiet_ticks != 24'hFFFFFF)
            quiet_ticks = quiet_ticks + 1'b1;
        case (phase_now)
            PH_IDLE:
                if (!hold_r && 32'(quiet_ticks) >= quiet_lim)
                begin
                    plane = '0;
                    pair  = '0;
                    start_row();
                end
            PH_SHIFT_LOW:
                phase_now = PH_SHIFT_HIGH;
            PH_SHIFT_HIGH:
                if (32'(col) != PANEL_WIDTH - 1)
                begin
                    col = col + 1'b1;
                    fetch_column();
                    phase_now = PH_SHIFT_LOW;
                end
                else
                begin
                    row_hold  = pair;
                    phase_now = PH_LATCH;
                end
            PH_LATCH:
            begin
                phase_ticks = '0;
                phase_now   = PH_ON;
            end
            PH_ON:
            begin
                phase_ticks = phase_ticks + 1'b1;
                if (32'(phase_ticks) >= on_lim)
                begin
                    pair = pair + 1'b1;
                    if (pair == 0)
                    begin
                        plane = plane + 1'b1;
                        if (plane == 0)
                        begin
                            phase_ticks = '0;
                            phase_now   = PH_GAP;
                        end
                        else
                            start_row();
                    end
                    else
                        start_row();
                end
            end
            PH_GAP:
            begin
                phase_ticks = phase_ticks + 1'b1;
                if (32'(phase_ticks) >= gap_lim)
                begin
                    phase_ticks = '0;
                    phase_now   = PH_IDLE;
                end
            end
            default:
                phase_now = PH_IDLE;
        endcase
    endfunction

    function void predict_beat(input logic [1:0] cmd, input logic [7:0] x, y, r, g, b);
        logic        refused;
        logic        busy;
        panel_beat_t lv;
        refused = 1'b0;
        busy = phase_now inside {PH_SHIFT_LOW, PH_SHIFT_HIGH, PH_LATCH, PH_ON};
        case (cmd)
            CMD_TICK:
                advance_scan();
            CMD_WRITE, CMD_CLEAR:
                if (busy)
                    refused = 1'b1;
                else
                begin
                    if (cmd == CMD_CLEAR)
                    begin
                        foreach (pixel_mirror[i])
                            pixel_mirror[i] = '0;
                    end
                    else if (x < PANEL_WIDTH && y < PANEL_HEIGHT)
                        pixel_mirror[y * PANEL_WIDTH + x] = {b, g, r};
                    quiet_ticks = '0;
                end
            default: ;
        endcase
        lv.color    = shift_hold;
        lv.sclk     = (phase_now == PH_SHIFT_HIGH);
        lv.row_addr = row_hold;
        lv.lat      = (phase_now == PH_LATCH);
        lv.blanked  = (phase_now != PH_ON);
        lv.active   = phase_now inside {PH_SHIFT_LOW, PH_SHIFT_HIGH, PH_LATCH, PH_ON};
        lv.refused  = refused;
        panel_levels_q.push_back(lv);
    endfunction

    function automatic plan_row_t beat_row(input logic [1:0] cmd, input logic [7:0] x, y,
                                           input logic [7:0] r, g, b, input bit typed,
                                           input panel_beat_t want);
        plan_row_t row;
        row = '{kind: ROW_BEAT, cmd: cmd, x: x, y: y, r: r, g: g, b: b, reg_idx: '0,
                reg_val: '0, typed: typed, want: want};
        return row;
    endfunction

    function automatic plan_row_t reg_row(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        plan_row_t row;
        row = '{kind: ROW_REG, cmd: CMD_TICK, x: '0, y: '0, r: '0, g: '0, b: '0,
                reg_idx: idx, reg_val: val, typed: 1'b0, want: IDLE_LEVELS};
        return row;
    endfunction

    function automatic void check_field(input string name, input int unsigned want, got);
        if (want != got)
        begin
            $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic send_beat(input logic [1:0] cmd, input logic [7:0] x, y, r, g, b);
        if (tx_idle_on && $urandom_range(0, 99) < 11)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < 11);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        column   <= x;
        line     <= y;
        red      <= r;
        green    <= g;
        blue     <= b;
        do @(posedge clk); while (in_stall);
        predict_beat(cmd, x, y, r, g, b);
    endtask

    // drain all beats, then let any store sweep finish
    task automatic settle();
        in_valid <= 1'b0;
        while (panel_levels_q.size() != 0)
            @(posedge clk);
        repeat (SWEEP_GUARD) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_TICKS_PER_US: tpu_r   = val[7:0];
            REG_BASE_ON_US:   base_r  = val[7:0];
            REG_QUIET_US:     quiet_r = val;
            REG_FRAME_GAP_US: gap_r   = val;
            REG_REFRESH_HOLD: hold_r  = val[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic reprogram(input logic [7:0] tpu, base, input logic [15:0] quiet, gap,
                             input logic hold);
        settle();
        write_reg(REG_TICKS_PER_US, {8'd0, tpu});
        write_reg(REG_BASE_ON_US, {8'd0, base});
        write_reg(REG_QUIET_US, quiet);
        write_reg(REG_FRAME_GAP_US, gap);
        write_reg(REG_REFRESH_HOLD, {15'd0, hold});
    endtask

    // write_pm: writes per thousand beats; the rest is mostly ticks
    task automatic run_phase(input int n_beats, input int write_pm);
        int         roll;
        logic [1:0] cmd;
        logic [7:0] x;
        logic [7:0] y;
        for (int k = 0; k < n_beats; k++)
        begin
            roll = int'($urandom_range(0, 999));
            x = 8'($urandom_range(0, 255));
            y = 8'($urandom_range(0, 255));
            if (roll < write_pm)
            begin
                cmd = CMD_WRITE;
                if ($urandom_range(0, 9) != 0)
                begin
                    x = 8'(x % PANEL_WIDTH);
                    y = 8'(y % PANEL_HEIGHT);
                end
            end
            else if (roll < write_pm + 3)
                cmd = CMD_CLEAR;
            else if (roll < write_pm + 23)
                cmd = CMD_UNUSED;
            else
                cmd = CMD_TICK;
            send_beat(cmd, x, y, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
        end
    endtask

    always @(posedge clk)
    begin
        panel_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (panel_levels_q.size() == 0)
            begin
                $display("%0t unexpected beat: expected none actual %0h %0h %0h %0h %0h %0h %0h",
                         $time, color_bits, shift_clock, row_address, latch, blank,
                         frame_active, write_refused);
                mismatches++;
            end
            else
            begin
                want = panel_levels_q.pop_front();
                check_field("color_bits", 32'(want.color), 32'(color_bits));
                check_field("shift_clock", 32'(want.sclk), 32'(shift_clock));
                check_field("row_address", 32'(want.row_addr), 32'(row_address));
                check_field("latch", 32'(want.lat), 32'(latch));
                check_field("blank", 32'(want.blanked), 32'(blank));
                check_field("frame_active", 32'(want.active), 32'(frame_active));
                check_field("write_refused", 32'(want.refused), 32'(write_refused));
            end
        end
    end

    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_holdoff)
            begin
                out_stall <= 1'b1;
                repeat (HOLDOFF_LEN) @(posedge clk);
                rx_holdoff = 1'b0;
                out_stall <= 1'b0;
            end
            else
                out_stall <= rx_idle_on && ($urandom_range(0, 99) < 11);
        end
    end

    initial
    begin
        #20_000_000;
        $display("led_matrix_bcm_scanner verification failed");
        $finish;
    end

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        command   <= CMD_TICK;
        column    <= '0;
        line      <= '0;
        red       <= '0;
        green     <= '0;
        blue      <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;

        foreach (pixel_mirror[i])
            pixel_mirror[i] = '0;
        phase_now   = PH_IDLE;
        plane       = '0;
        pair        = '0;
        col         = '0;
        phase_ticks = '0;
        quiet_ticks = '0;
        row_hold    = '0;
        shift_hold  = '0;
        tpu_r       = 8'd25;
        base_r      = 8'd4;
        quiet_r     = 16'd1000;
        gap_r       = 16'd1000;
        hold_r      = 1'b0;

        plan.push_back(beat_row(CMD_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1, IDLE_LEVELS));
        plan.push_back(beat_row(CMD_WRITE, 8'd0, 8'd0, 8'hFF, 8'hFF, 8'hFF, 1, IDLE_LEVELS));
        plan.push_back(beat_row(CMD_WRITE, 8'd63, 8'd31, 8'h00, 8'hFF, 8'h00, 1, IDLE_LEVELS));
        plan.push_back(beat_row(CMD_WRITE, 8'd64, 8'd0, 8'hFF, 8'h00, 8'hFF, 1, IDLE_LEVELS));
        plan.push_back(beat_row(CMD_WRITE, 8'd0, 8'd32, 8'h12, 8'h34, 8'h56, 1, IDLE_LEVELS));
        plan.push_back(beat_row(CMD_WRITE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, IDLE_LEVELS));
        plan.push_back(beat_row(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, IDLE_LEVELS));
        plan.push_back(beat_row(CMD_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1, IDLE_LEVELS));
        plan.push_back(beat_row(CMD_WRITE, 8'd0, 8'd16, 8'h55, 8'hAA, 8'h0F, 1, IDLE_LEVELS));
        plan.push_back(beat_row(CMD_WRITE, 8'd1, 8'd0, 8'h80, 8'h01, 8'hFF, 1, IDLE_LEVELS));
        plan.push_back(beat_row(CMD_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1, IDLE_LEVELS));
        plan.push_back(reg_row(REG_REFRESH_HOLD, 16'd1));
        plan.push_back(reg_row(REG_TICKS_PER_US, 16'd0));
        plan.push_back(reg_row(REG_QUIET_US, 16'd0));
        plan.push_back(beat_row(CMD_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1, IDLE_LEVELS));
        plan.push_back(reg_row(REG_REFRESH_HOLD, 16'd0));
        plan.push_back(beat_row(CMD_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 0, IDLE_LEVELS));
        plan.push_back(beat_row(CMD_WRITE, 8'd5, 8'd5, 8'hFF, 8'hFF, 8'hFF, 1, REFUSED_LEVELS));
        plan.push_back(beat_row(CMD_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1, REFUSED_LEVELS));
        plan.push_back(beat_row(CMD_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 0, IDLE_LEVELS));
        plan.push_back(beat_row(CMD_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 0, IDLE_LEVELS));
        plan.push_back(beat_row(CMD_UNUSED, 8'd7, 8'd9, 8'd1, 8'd2, 8'd3, 0, IDLE_LEVELS));
        plan.push_back(beat_row(CMD_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 0, IDLE_LEVELS));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
            begin
                if (i == 0 || plan[i - 1].kind != ROW_REG)
                    settle();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end
            else
            begin
                send_beat(plan[i].cmd, plan[i].x, plan[i].y, plan[i].r, plan[i].g, plan[i].b);
                if (plan[i].typed)
                    panel_levels_q[panel_levels_q.size() - 1] = plan[i].want;
            end
        end

        // fill the framebuffer with refresh held off
        reprogram(8'd25, 8'd4, 16'd1000, 16'd1000, 1'b1);
        run_phase(250, 850);

        // fastest weighted timing; no sender gaps, one long holdoff
        reprogram(8'd1, 8'd1, 16'd0, 16'd3, 1'b0);
        tx_idle_on = 1'b0;
        rx_holdoff = 1'b1;
        run_phase(400, 20);
        tx_idle_on = 1'b1;

        reprogram(8'd0, 8'd0, 16'd0, 16'd0, 1'b0);
        rx_idle_on = 1'b0;
        run_phase(200, 30);
        rx_idle_on = 1'b1;

        // hold set while a frame is running
        reprogram(8'd1, 8'd1, 16'd0, 16'd0, 1'b1);
        run_phase(150, 20);

        reprogram(8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 1'b0);
        run_phase(100, 50);

        reprogram(8'd2, 8'd3, 16'd5, 16'd20, 1'b0);
        run_phase(200, 120);

        repeat (3)
        begin
            reprogram(8'($urandom_range(0, 3)), 8'($urandom_range(0, 4)),
                      16'($urandom_range(0, 8)), 16'($urandom_range(0, 30)),
                      $urandom_range(0, 3) == 0);
            run_phase(60, int'($urandom_range(0, 200)));
        end

        in_valid <= 1'b0;
        while (panel_levels_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (mismatches == 0)
            $display("led_matrix_bcm_scanner verification clean");
        else
            $display("led_matrix_bcm_scanner verification failed");
        $finish;
    end

endmodule

### sim.f
hdl/lmbs_pkg.sv
hdl/lmbs_front.sv
hdl/lmbs_back.sv
hdl/led_matrix_bcm_scanner.sv
tb/led_matrix_bcm_scanner_tb.sv
